// File: design/icpr_pkg.sv
// package for the icmp probe reply classifier: constants, result codes, field bundle
`timescale 1ns / 1ps

package icpr_pkg;

    // icmp header values of interest
    localparam logic [7:0] TYPE_TIME_EXCEEDED = 8'd11;
    localparam logic [7:0] CODE_IN_TRANSIT    = 8'd0;
    localparam logic [7:0] TYPE_ECHO_REPLY    = 8'd0;
    localparam logic [8:0] ICMP_HDR_BYTES     = 9'd8;

    // byte offsets inside an icmp header
    localparam logic [8:0] OFS_CODE      = 9'd1;
    localparam logic [8:0] OFS_IDENT_HI  = 9'd4;
    localparam logic [8:0] OFS_IDENT_LO  = 9'd5;
    localparam logic [8:0] OFS_SEQ_HI    = 9'd6;
    localparam logic [8:0] OFS_SEQ_LO    = 9'd7;

    localparam logic [7:0] POS_MAX = 8'hFF;

    // classification result
    typedef enum logic [1:0] {
        KIND_NO_MATCH      = 2'd0,
        KIND_TIME_EXCEEDED = 2'd1,
        KIND_ECHO_REPLY    = 2'd2
    } reply_kind_t;

    // packet fields as seen after the current byte is captured
    typedef struct packed {
        logic [8:0]  len;
        logic [5:0]  outer_hdr;
        logic [7:0]  outer_type;
        logic [7:0]  outer_code;
        logic [15:0] outer_ident;
        logic [15:0] outer_seq;
        logic [5:0]  inner_hdr;
        logic [15:0] inner_ident;
        logic [15:0] inner_seq;
    } pkt_fields_t;

endpackage

// File: design/icpr_parser.sv
// byte parser: tracks position and captures header fields at their offsets
`timescale 1ns / 1ps

module icpr_parser (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 advance,
    input  logic [7:0]           packet_byte,
    input  logic                 last_byte,
    output icpr_pkg::pkt_fields_t fields
);
    import icpr_pkg::*;

    logic [7:0]  pos_reg, pos_next;
    logic [5:0]  outer_hdr_reg;
    logic [7:0]  outer_type_reg;
    logic [7:0]  outer_code_reg;
    logic [15:0] outer_ident_reg;
    logic [15:0] outer_seq_reg;
    logic [5:0]  inner_hdr_reg;
    logic [15:0] inner_ident_reg;
    logic [15:0] inner_seq_reg;

    logic [8:0]  pos9;
    logic [8:0]  outer_ofs;
    logic [8:0]  inner_ip_ofs;
    logic [8:0]  inner_icmp_ofs;
    pkt_fields_t cur;

    // offsets for this byte, then field capture including the current byte
    always_comb begin
        pos9 = {1'b0, pos_reg};
        cur.outer_hdr = (pos_reg == 8'd0) ? {packet_byte[3:0], 2'b00} : outer_hdr_reg;
        outer_ofs = {3'b000, cur.outer_hdr};
        inner_ip_ofs = outer_ofs + ICMP_HDR_BYTES;
        cur.inner_hdr = (pos9 == inner_ip_ofs) ? {packet_byte[3:0], 2'b00} : inner_hdr_reg;
        inner_icmp_ofs = inner_ip_ofs + {3'b000, cur.inner_hdr};

        cur.len = pos9 + 9'd1;
        cur.outer_type  = (pos9 == outer_ofs) ? packet_byte : outer_type_reg;
        cur.outer_code  = (pos9 == outer_ofs + OFS_CODE) ? packet_byte : outer_code_reg;
        cur.outer_ident = outer_ident_reg;
        cur.outer_seq   = outer_seq_reg;
        cur.inner_ident = inner_ident_reg;
        cur.inner_seq   = inner_seq_reg;
        if (pos9 == outer_ofs + OFS_IDENT_HI) begin
            cur.outer_ident[15:8] = packet_byte;
        end
        if (pos9 == outer_ofs + OFS_IDENT_LO) begin
            cur.outer_ident[7:0] = packet_byte;
        end
        if (pos9 == outer_ofs + OFS_SEQ_HI) begin
            cur.outer_seq[15:8] = packet_byte;
        end
        if (pos9 == outer_ofs + OFS_SEQ_LO) begin
            cur.outer_seq[7:0] = packet_byte;
        end
        if (pos9 == inner_icmp_ofs + OFS_IDENT_HI) begin
            cur.inner_ident[15:8] = packet_byte;
        end
        if (pos9 == inner_icmp_ofs + OFS_IDENT_LO) begin
            cur.inner_ident[7:0] = packet_byte;
        end
        if (pos9 == inner_icmp_ofs + OFS_SEQ_HI) begin
            cur.inner_seq[15:8] = packet_byte;
        end
        if (pos9 == inner_icmp_ofs + OFS_SEQ_LO) begin
            cur.inner_seq[7:0] = packet_byte;
        end
    end

    // saturating byte position
    assign pos_next = (pos_reg == POS_MAX) ? POS_MAX : pos_reg + 8'd1;

    // packet state, cleared on reset and after the final byte
    always_ff @(posedge aclk) begin
        if (!aresetn || (advance && last_byte)) begin
            pos_reg         <= '0;
            outer_hdr_reg   <= '0;
            outer_type_reg  <= '0;
            outer_code_reg  <= '0;
            outer_ident_reg <= '0;
            outer_seq_reg   <= '0;
            inner_hdr_reg   <= '0;
            inner_ident_reg <= '0;
            inner_seq_reg   <= '0;
        end else if (advance) begin
            pos_reg         <= pos_next;
            outer_hdr_reg   <= cur.outer_hdr;
            outer_type_reg  <= cur.outer_type;
            outer_code_reg  <= cur.outer_code;
            outer_ident_reg <= cur.outer_ident;
            outer_seq_reg   <= cur.outer_seq;
            inner_hdr_reg   <= cur.inner_hdr;
            inner_ident_reg <= cur.inner_ident;
            inner_seq_reg   <= cur.inner_seq;
        end
    end

    assign fields = cur;

endmodule

// File: design/icpr_classify.sv
// classifier: decides the reply kind from the captured fields
`timescale 1ns / 1ps

module icpr_classify (
    input  icpr_pkg::pkt_fields_t fields,
    input  logic [15:0]           probe_identifier,
    input  logic [15:0]           expected_sequence,
    output icpr_pkg::reply_kind_t reply_kind
);
    import icpr_pkg::*;

    logic [8:0] outer_need;
    logic [8:0] inner_need;
    logic       te_hit;
    logic       echo_hit;

    // minimum lengths for each kind of reply
    assign outer_need = {3'b000, fields.outer_hdr} + ICMP_HDR_BYTES;
    assign inner_need = outer_need + {3'b000, fields.inner_hdr} + ICMP_HDR_BYTES;

    // match tests
    assign te_hit = (fields.outer_type == TYPE_TIME_EXCEEDED)
                 && (fields.outer_code == CODE_IN_TRANSIT)
                 && (fields.len >= inner_need)
                 && (fields.inner_ident == probe_identifier)
                 && (fields.inner_seq == expected_sequence);

    assign echo_hit = (fields.outer_type == TYPE_ECHO_REPLY)
                   && (fields.len >= outer_need)
                   && (fields.outer_ident == probe_identifier)
                   && (fields.outer_seq == expected_sequence);

    always_comb begin
        if (te_hit) begin
            reply_kind = KIND_TIME_EXCEEDED;
        end else if (echo_hit) begin
            reply_kind = KIND_ECHO_REPLY;
        end else begin
            reply_kind = KIND_NO_MATCH;
        end
    end

endmodule

// File: design/icmp_probe_reply_classifier.sv
// top level of the icmp probe reply classifier
//
//   channel   direction  handshake            payload
//   s_        in         s_valid / s_ready    s_packet_byte, s_last_byte, s_expected_sequence
//   m_        out        m_valid / m_ready    m_reply_kind
//   cfg_      in         cfg_valid/cfg_ready  cfg_probe_identifier
//
// one byte item per cycle unless stalled; bytes pass an input register, then the parser and
// classifier logic, and the final byte of a packet loads the result register
// a result is registered when its final byte moves on from the input register
// s_ready drops only while a final byte waits on a result that m_ready holds
// aresetn is synchronous; it clears packet state, valids and the identifier
`timescale 1ns / 1ps

module icmp_probe_reply_classifier (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_packet_byte,
    input  logic        s_last_byte,
    input  logic [15:0] s_expected_sequence,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_reply_kind,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_probe_identifier
);
    import icpr_pkg::*;

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;
    logic [15:0] in_seq_reg;
    logic        out_valid_reg;
    reply_kind_t kind_reg;
    reply_kind_t kind_next;
    logic [15:0] probe_id_reg;
    logic        advance;
    pkt_fields_t fields;

    // a byte moves on unless it would overwrite a result not yet taken
    assign advance = in_valid_reg && (!in_last_reg || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_packet_byte;
            in_last_reg <= s_last_byte;
            in_seq_reg  <= s_expected_sequence;
        end
    end

    // probe identifier register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            probe_id_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            probe_id_reg <= cfg_probe_identifier;
        end
    end

    icpr_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (advance),
        .packet_byte (in_byte_reg),
        .last_byte   (in_last_reg),
        .fields      (fields)
    );

    icpr_classify u_classify (
        .fields            (fields),
        .probe_identifier  (probe_id_reg),
        .expected_sequence (in_seq_reg),
        .reply_kind        (kind_next)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && in_last_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_last_reg) begin
            kind_reg <= kind_next;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_reply_kind = kind_reg;

endmodule

// File: design/icpr_checker.sv
// port checker for the icmp probe reply classifier, bound to the top level
`timescale 1ns / 1ps

module icpr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        s_last_byte,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_reply_kind
);

    // a held result keeps its value
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_reply_kind))
        else $error("result changed while stalled");

    // the unused code never shows
    a_kind_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_reply_kind[1] && m_reply_kind[0]))
        else $error("reply kind out of range");

    // input backpressure only comes from a stalled result
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without output stall");

    // a fresh result follows an accepted final byte item
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready && s_last_byte, 2))
        else $error("result without a final byte");

endmodule

bind icmp_probe_reply_classifier icpr_checker u_icpr_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .s_last_byte  (s_last_byte),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_reply_kind (m_reply_kind)
);
